// ===== rtl/core/sg2h2_pkg.sv =====
`timescale 1ns / 1ps

package sg2h2_pkg;

   // Angle ports and the angle register are 16 bits wide
   localparam int ANGLE_IN_WIDTH = 16;

   // Steering coefficients in Q.16, signed, with headroom for the 3x terms
   localparam int COEF_WIDTH = 20;

   // Rotation unit: one step per pipeline stage
   localparam int CORDIC_STEPS = 30;
   localparam logic signed [33:0] CORDIC_GAIN = 34'sh026DD3B6A;

   // atan(2^-i) in units of 2^-32 turn
   localparam logic [31:0] ATAN_TURN [0:CORDIC_STEPS-1] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
      32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
      32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
   };

   // Quadrant codes taken from the top two phase bits
   localparam logic [1:0] QUAD_0 = 2'd0;
   localparam logic [1:0] QUAD_1 = 2'd1;
   localparam logic [1:0] QUAD_2 = 2'd2;
   localparam logic [1:0] QUAD_3 = 2'd3;

   // Control register indexes
   localparam logic REG_FIXED_ANGLE  = 1'b0;
   localparam logic REG_ANGLE_SOURCE = 1'b1;

endpackage

// ===== rtl/core/steer_g2_h2_basis_responses.sv =====
`timescale 1ns / 1ps

// G2/H2 steering of separable basis responses, one pixel per beat.
// Input channel: raise start with the angle and the seven basis responses of
// one pixel; the beat is taken at any edge where start is high, busy is never
// raised, so a new pixel may enter every cycle.
// Result channel: rsp_valid strobes for one cycle with the steered G2 and H2
// values and the clipped flag; the receiver must take it then.
// Control port: csr_we with csr_index writes fixed_angle (index 0) or
// angle_source (index 1); write only while no pixel is in flight.
// Path from the accepting edge to rsp_valid and the result, in order: one entry
// stage, 30 rotation stages (one sine/cosine step each), a quadrant fold stage,
// three coefficient stages, a multiply stage, a sum stage and the output
// round/saturate stage. Throughput: one pixel per cycle, set by the fully
// pipelined rotation chain.
// Reset clears the valid bits of every stage and both control registers;
// pixels in flight are dropped. No result can be held off, so nothing stalls.
module steer_g2_h2_basis_responses #(
   parameter int SAMPLE_WIDTH = 24,
   parameter int ANGLE_WIDTH  = 16
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        start,
   output logic                                        busy,
   input  logic [sg2h2_pkg::ANGLE_IN_WIDTH-1:0]        req_pixel_angle,
   input  logic signed [SAMPLE_WIDTH-1:0]              req_g2_basis_a,
   input  logic signed [SAMPLE_WIDTH-1:0]              req_g2_basis_b,
   input  logic signed [SAMPLE_WIDTH-1:0]              req_g2_basis_c,
   input  logic signed [SAMPLE_WIDTH-1:0]              req_h2_basis_a,
   input  logic signed [SAMPLE_WIDTH-1:0]              req_h2_basis_b,
   input  logic signed [SAMPLE_WIDTH-1:0]              req_h2_basis_c,
   input  logic signed [SAMPLE_WIDTH-1:0]              req_h2_basis_d,
   input  logic                                        csr_we,
   input  logic                                        csr_index,
   input  logic [sg2h2_pkg::ANGLE_IN_WIDTH-1:0]        csr_data,
   output logic                                        rsp_valid,
   output logic signed [SAMPLE_WIDTH-1:0]              rsp_g_steered,
   output logic signed [SAMPLE_WIDTH-1:0]              rsp_h_steered,
   output logic                                        rsp_clipped
);

   localparam int CW      = sg2h2_pkg::COEF_WIDTH;
   localparam int NS      = sg2h2_pkg::CORDIC_STEPS;
   localparam int PW      = CW + SAMPLE_WIDTH;
   localparam int SUMW    = PW + 2;
   localparam int LATENCY = NS + 8;
   localparam int SDEPTH  = NS + 4;
   localparam logic [31:0] AMASK = (32'd1 << ANGLE_WIDTH) - 32'd1;
   localparam logic signed [SAMPLE_WIDTH-1:0] SMAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
   localparam logic signed [SAMPLE_WIDTH-1:0] SMIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

   // Round by 2^16 and saturate; returns {clip, value}
   function automatic logic [SAMPLE_WIDTH:0] round_sat(input logic signed [SUMW-1:0] v);
      logic signed [SUMW-1:0] r;
      logic [SUMW-SAMPLE_WIDTH:0] top;
      r   = (v + (SUMW'(1) <<< 15)) >>> 16;
      top = r[SUMW-1:SAMPLE_WIDTH-1];
      if ((&top) || !(|top)) begin
         round_sat = {1'b0, r[SAMPLE_WIDTH-1:0]};
      end else if (r[SUMW-1]) begin
         round_sat = {1'b1, SMIN};
      end else begin
         round_sat = {1'b1, SMAX};
      end
   endfunction

   // Control registers
   logic [sg2h2_pkg::ANGLE_IN_WIDTH-1:0] fixed_angle_ff;
   logic                                 angle_source_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fixed_angle_ff  <= '0;
         angle_source_ff <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            sg2h2_pkg::REG_FIXED_ANGLE:  fixed_angle_ff  <= csr_data;
            sg2h2_pkg::REG_ANGLE_SOURCE: angle_source_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   // Entry: pick the angle and map it onto a 32-bit phase
   logic                                 accept;
   logic [sg2h2_pkg::ANGLE_IN_WIDTH-1:0] angle_sel;
   logic [31:0]                          phase_in;

   assign busy      = 1'b0;
   assign accept    = start && !busy;
   assign angle_sel = angle_source_ff ? req_pixel_angle : fixed_angle_ff;
   assign phase_in  = ((32'(angle_sel)) & AMASK) << (32 - ANGLE_WIDTH);

   logic                           vld_ff  [0:LATENCY-1];
   logic signed [33:0]             x_ff    [0:NS];
   logic signed [33:0]             y_ff    [0:NS];
   logic signed [32:0]             z_ff    [0:NS];
   logic [1:0]                     quad_ff [0:NS];
   logic signed [SAMPLE_WIDTH-1:0] smp_ff  [0:SDEPTH][0:6];

   // Valid line
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else begin
         vld_ff[0] <= accept;
      end
   end

   for (genvar k = 1; k < LATENCY; k++) begin : g_vld
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else begin
            vld_ff[k] <= vld_ff[k-1];
         end
      end
   end

   // Load the entry stage
   always_ff @(posedge clock) begin
      x_ff[0]      <= sg2h2_pkg::CORDIC_GAIN;
      y_ff[0]      <= '0;
      z_ff[0]      <= {3'b000, phase_in[29:0]};
      quad_ff[0]   <= phase_in[31:30];
      smp_ff[0][0] <= req_g2_basis_a;
      smp_ff[0][1] <= req_g2_basis_b;
      smp_ff[0][2] <= req_g2_basis_c;
      smp_ff[0][3] <= req_h2_basis_a;
      smp_ff[0][4] <= req_h2_basis_b;
      smp_ff[0][5] <= req_h2_basis_c;
      smp_ff[0][6] <= req_h2_basis_d;
   end

   // Carry the samples alongside the angle work
   for (genvar k = 1; k <= SDEPTH; k++) begin : g_smp
      always_ff @(posedge clock) begin
         smp_ff[k] <= smp_ff[k-1];
      end
   end

   // Rotation chain, one step per stage
   for (genvar i = 0; i < NS; i++) begin : g_cordic
      logic signed [33:0] x_in;
      logic signed [33:0] y_in;
      logic signed [32:0] z_in;
      logic signed [32:0] step_ang;

      assign step_ang = $signed({1'b0, sg2h2_pkg::ATAN_TURN[i]});

      always_comb begin
         if (!z_ff[i][32]) begin
            x_in = x_ff[i] - (y_ff[i] >>> i);
            y_in = y_ff[i] + (x_ff[i] >>> i);
            z_in = z_ff[i] - step_ang;
         end else begin
            x_in = x_ff[i] + (y_ff[i] >>> i);
            y_in = y_ff[i] - (x_ff[i] >>> i);
            z_in = z_ff[i] + step_ang;
         end
      end

      always_ff @(posedge clock) begin
         x_ff[i+1]    <= x_in;
         y_ff[i+1]    <= y_in;
         z_ff[i+1]    <= z_in;
         quad_ff[i+1] <= quad_ff[i];
      end
   end

   // Fold the quadrant, round to Q1.16 and clamp
   logic signed [34:0] xe, ye, fc, fs, rc, rs;
   logic signed [17:0] c_in, s_in, c_ff, s_ff;

   assign xe = 35'(x_ff[NS]);
   assign ye = 35'(y_ff[NS]);

   always_comb begin
      case (quad_ff[NS])
         sg2h2_pkg::QUAD_1: begin fc = -ye; fs = xe;  end
         sg2h2_pkg::QUAD_2: begin fc = -xe; fs = -ye; end
         sg2h2_pkg::QUAD_3: begin fc = ye;  fs = -xe; end
         default:           begin fc = xe;  fs = ye;  end
      endcase
      rc = (fc + 35'sd8192) >>> 14;
      rs = (fs + 35'sd8192) >>> 14;
      if (rc > 35'sd65536) begin
         c_in = 18'sd65536;
      end else if (rc < -35'sd65536) begin
         c_in = -18'sd65536;
      end else begin
         c_in = rc[17:0];
      end
      if (rs > 35'sd65536) begin
         s_in = 18'sd65536;
      end else if (rs < -35'sd65536) begin
         s_in = -18'sd65536;
      end else begin
         s_in = rs[17:0];
      end
   end

   always_ff @(posedge clock) begin
      c_ff <= c_in;
      s_ff <= s_in;
   end

   // Second-order products of cosine and sine
   logic signed [35:0] cc_p, cs_p, ss_p;
   logic signed [33:0] cc_ff, cs_ff, ss_ff;
   logic signed [17:0] c1_ff, s1_ff;

   assign cc_p = c_ff * c_ff;
   assign cs_p = c_ff * s_ff;
   assign ss_p = s_ff * s_ff;

   always_ff @(posedge clock) begin
      cc_ff <= cc_p[33:0];
      cs_ff <= cs_p[33:0];
      ss_ff <= ss_p[33:0];
      c1_ff <= c_ff;
      s1_ff <= s_ff;
   end

   // G coefficients, and third-order products for H
   logic signed [35:0] cc_r, ss_r, m2cs;
   logic signed [CW-1:0] ga_in, gb_in, gc_in, ga_ff, gb_ff, gc_ff;
   logic signed [51:0] ccc_in, ccs_in, css_in, sss_in;
   logic signed [51:0] ccc_ff, ccs_ff, css_ff, sss_ff;

   always_comb begin
      m2cs   = -(36'(cs_ff) <<< 1);
      cc_r   = (36'(cc_ff) + 36'sd32768) >>> 16;
      ss_r   = (36'(ss_ff) + 36'sd32768) >>> 16;
      m2cs   = (m2cs + 36'sd32768) >>> 16;
      ga_in  = cc_r[CW-1:0];
      gb_in  = m2cs[CW-1:0];
      gc_in  = ss_r[CW-1:0];
      ccc_in = cc_ff * c1_ff;
      ccs_in = cc_ff * s1_ff;
      css_in = ss_ff * c1_ff;
      sss_in = ss_ff * s1_ff;
   end

   always_ff @(posedge clock) begin
      ga_ff  <= ga_in;
      gb_ff  <= gb_in;
      gc_ff  <= gc_in;
      ccc_ff <= ccc_in;
      ccs_ff <= ccs_in;
      css_ff <= css_in;
      sss_ff <= sss_in;
   end

   // H coefficients, rounded by 2^32
   localparam logic signed [54:0] HALF32 = 55'sd2147483648;
   logic signed [54:0] va, vb, vc, vd;
   logic signed [CW-1:0] coef_ff [0:6];

   always_comb begin
      va = ((55'(ccc_ff)) + HALF32) >>> 32;
      vb = (-((55'(ccs_ff) <<< 1) + 55'(ccs_ff)) + HALF32) >>> 32;
      vc = (((55'(css_ff) <<< 1) + 55'(css_ff)) + HALF32) >>> 32;
      vd = (-(55'(sss_ff)) + HALF32) >>> 32;
   end

   always_ff @(posedge clock) begin
      coef_ff[0] <= ga_ff;
      coef_ff[1] <= gb_ff;
      coef_ff[2] <= gc_ff;
      coef_ff[3] <= va[CW-1:0];
      coef_ff[4] <= vb[CW-1:0];
      coef_ff[5] <= vc[CW-1:0];
      coef_ff[6] <= vd[CW-1:0];
   end

   // Weight each basis response
   logic signed [PW-1:0] prod_ff [0:6];

   for (genvar k = 0; k < 7; k++) begin : g_mul
      always_ff @(posedge clock) begin
         prod_ff[k] <= coef_ff[k] * smp_ff[SDEPTH][k];
      end
   end

   // Sum the weighted responses
   logic signed [SUMW-1:0] gsum_ff, hsum_ff;

   always_ff @(posedge clock) begin
      gsum_ff <= SUMW'(prod_ff[0]) + SUMW'(prod_ff[1]) + SUMW'(prod_ff[2]);
      hsum_ff <= SUMW'(prod_ff[3]) + SUMW'(prod_ff[4])
               + SUMW'(prod_ff[5]) + SUMW'(prod_ff[6]);
   end

   // Round, saturate and drive the result beat
   logic [SAMPLE_WIDTH:0] g_sat, h_sat;

   assign g_sat = round_sat(gsum_ff);
   assign h_sat = round_sat(hsum_ff);

   always_ff @(posedge clock) begin
      rsp_g_steered <= g_sat[SAMPLE_WIDTH-1:0];
      rsp_h_steered <= h_sat[SAMPLE_WIDTH-1:0];
      rsp_clipped   <= g_sat[SAMPLE_WIDTH] | h_sat[SAMPLE_WIDTH];
   end

   assign rsp_valid = vld_ff[LATENCY-1];

   // Every result beat stems from an earlier input beat taken with start high
   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LATENCY))
      else $error("result beat without matching input beat");

   // A clipped result sits at a limit
   a_clip: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_clipped) |->
         (rsp_g_steered == SMAX || rsp_g_steered == SMIN ||
          rsp_h_steered == SMAX || rsp_h_steered == SMIN))
      else $error("clipped flag without a saturated output");

   // Folded cosine and sine stay within one
   a_unit: assert property (@(posedge clock) disable iff (reset)
      vld_ff[NS+1] |-> (c_ff <= 18'sd65536 && c_ff >= -18'sd65536 &&
                        s_ff <= 18'sd65536 && s_ff >= -18'sd65536))
      else $error("cosine or sine out of unit range");

endmodule
